// ===== rtl/core/wgm_pkg.sv =====
// wgm_pkg: shared types, constants and helpers for the wildcard glob matcher
`default_nettype none

package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 32;

  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_ONE  = 8'h3F;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_EMPTY   = 2'd3
  } cmd_t;

  // signals passed from one cell to the next
  typedef struct packed {
    logic adv;
    logic clo;
    logic st;
  } cell_link_t;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic fresh;
    logic step;
    logic load;
  } cell_ctl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wgm_cell.sv =====
// wgm_cell: one pattern position of the bit-parallel matcher chain
`default_nettype none

module wgm_cell
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int IDX = 0,
  localparam int LW = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic       clk,
  input  wire cell_ctl_t  ctl,
  input  wire logic [LW-1:0] len,
  input  wire logic [7:0] ch,
  input  wire cell_link_t link_in,
  output cell_link_t      link_out,
  output logic            nxt
);

  logic [7:0] pch;
  logic       star;
  logic       one;
  logic       st;
  logic       act;

  logic used;
  logic hit_here;
  logic eq;

  always_comb begin
    used     = len > LW'(IDX);
    hit_here = (ctl.fresh ? link_in.st : act) & used;
    eq       = one | (pch == fold_case(ch));
    nxt      = (hit_here & star) | link_in.adv | link_in.clo;
    link_out.adv = hit_here & ~star & eq;
    link_out.clo = nxt & used & star;
    link_out.st  = used & st;
  end

  always_ff @(posedge clk) begin
    if (ctl.load && len == LW'(IDX)) begin
      pch  <= fold_case(ch);
      star <= (ch == CHAR_STAR);
      one  <= (ch == CHAR_ONE);
      st   <= link_in.st & (ch == CHAR_STAR);
    end
    if (ctl.step) begin
      act <= nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_glob_match.sv =====
// wildcard_glob_match: case-insensitive glob matcher over a streamed subject
//
// input beats carry a command in s_axis_tuser: clear pattern, append a pattern
// byte (s_axis_tdata), a subject byte (s_axis_tdata, s_axis_tlast on the final
// one) or an empty subject. a final subject byte or an empty subject yields one
// output beat with the match flag and the pattern overflow flag.
// every pattern position is a cell in a row; each subject byte steps all cells
// at once, with star closure rippling along the row in the same cycle.
// throughput is one input beat per cycle for every command while no result stalls;
// a final subject byte's result reaches the master side in the cycle after acceptance.
// the output register frees while the receiver takes the beat, so a new input
// beat is taken in the same cycle; while the receiver stalls with a result
// pending, s_axis_tready stays low.
// reset empties the pattern, clears the overflow flag and drops any pending
// result; no clearing pass is needed.
`default_nettype none

module wildcard_glob_match
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
  input  wire logic [1:0] s_axis_tuser,   // [1:0] cmd
  input  wire logic       s_axis_tlast,   // last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] match, [1] pattern_overflow, [7:2] zero
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [LW-1:0] len;
  logic          ovf;
  logic          fresh;
  logic          match;

  logic       fire;
  cmd_t       cmd;
  logic       full;
  cell_ctl_t  ctl;
  cell_link_t link [0:MAX_PATTERN];
  logic [MAX_PATTERN:0] nxt_vec;
  logic       hit;

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign fire = s_axis_tvalid & s_axis_tready;
  assign cmd  = cmd_t'(s_axis_tuser);
  assign full = (len == LW'(MAX_PATTERN));

  always_comb begin
    ctl.fresh = fresh;
    ctl.step  = fire && cmd == CMD_SUBJECT;
    ctl.load  = fire && cmd == CMD_APPEND && !full;
  end

  assign link[0] = '{adv: 1'b0, clo: 1'b0, st: 1'b1};

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wgm_cell #(
      .MAX_PATTERN(MAX_PATTERN),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .len     (len),
      .ch      (s_axis_tdata),
      .link_in (link[i]),
      .link_out(link[i+1]),
      .nxt     (nxt_vec[i])
    );
  end

  assign nxt_vec[MAX_PATTERN] = link[MAX_PATTERN].adv | link[MAX_PATTERN].clo;
  assign hit = (len != '0) & nxt_vec[len];

  assign m_axis_tdata = {6'b0, ovf, match};

  always_ff @(posedge clk) begin
    if (rst) begin
      len           <= '0;
      ovf           <= 1'b0;
      fresh         <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (fire) begin
        case (cmd)
          CMD_CLEAR: begin
            len   <= '0;
            ovf   <= 1'b0;
            fresh <= 1'b1;
          end
          CMD_APPEND: begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              len <= len + 1'b1;
            end
            fresh <= 1'b1;
          end
          CMD_SUBJECT: begin
            fresh <= s_axis_tlast;
            if (s_axis_tlast) begin
              m_axis_tvalid <= 1'b1;
              match         <= hit;
            end
          end
          CMD_EMPTY: begin
            fresh         <= 1'b1;
            m_axis_tvalid <= 1'b1;
            match         <= 1'b0;
          end
          default: begin
            fresh <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wgm_checker.sv =====
// wgm_checker: port-level assertions for the glob matcher, bound to the top
`default_nettype none

module wgm_checker
  import wgm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic [1:0] s_axis_tuser,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  logic fire;
  assign fire = s_axis_tvalid & s_axis_tready;

  // a result beat only follows an accepted input beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(fire))
    else $error("result beat without accepted input");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // empty subject never matches
  assert property (@(posedge clk) disable iff (rst)
    fire && s_axis_tuser == CMD_EMPTY |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("empty subject reported a match");

  // subject right after a clear sees an empty pattern
  assert property (@(posedge clk) disable iff (rst)
    fire && s_axis_tuser == CMD_CLEAR ##1
    fire && s_axis_tuser == CMD_SUBJECT && s_axis_tlast
    |=> m_axis_tvalid && m_axis_tdata[1:0] == 2'b00)
    else $error("match or overflow after pattern clear");

endmodule

bind wildcard_glob_match wgm_checker u_wgm_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// ===== test/glob_verdict_checker.sv =====
`timescale 1ns / 100ps
// glob_verdict_checker: predicts and checks the verdict beats of the wildcard glob matcher

module glob_verdict_checker
  import wgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] ch
  input  logic [1:0] s_tuser,    // [1:0] cmd
  input  logic       s_tlast,    // last
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,    // [0] match, [1] pattern_overflow, [7:2] zero
  output int         mismatches,
  output int         pending,
  output int         verdicts,
  output int         hits
);

  localparam int DEPTH = MAX_PATTERN_DEF;

  typedef logic [DEPTH:0] pos_set_t;

  typedef struct packed {
    logic hit;
    logic overflow;
  } verdict_t;

  verdict_t   expected_verdicts[$];
  logic [7:0] pattern [DEPTH];
  int         pattern_len;
  pos_set_t   live;
  logic       overflowed;
  int         n_bad;
  int         n_verdicts;
  int         n_hits;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic pos_set_t close_stars(input pos_set_t s);
    pos_set_t r;
    r = s;
    for (int i = 0; i < pattern_len; i++) begin
      if (r[i] && pattern[i] == CHAR_STAR) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic pos_set_t start_positions();
    return close_stars(pos_set_t'(1));
  endfunction

  function automatic pos_set_t step_positions(input pos_set_t s, input logic [7:0] c);
    pos_set_t r;
    r = '0;
    for (int i = 0; i < pattern_len; i++) begin
      if (s[i]) begin
        if (pattern[i] == CHAR_STAR) begin
          r[i] = 1'b1;
        end else if (pattern[i] == CHAR_ONE || lower(pattern[i]) == lower(c)) begin
          r[i+1] = 1'b1;
        end
      end
    end
    return close_stars(r);
  endfunction

  task automatic flag(input string what);
    n_bad++;
    if (n_bad <= 10) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      expected_verdicts.delete();
      for (int i = 0; i < DEPTH; i++) begin
        pattern[i] = 8'h00;
      end
      pattern_len = 0;
      overflowed = 1'b0;
      live = start_positions();
    end else begin
      // output side first: a verdict leaving now belongs to an earlier input beat
      if (m_tvalid && m_tready) begin
        n_verdicts++;
        if (m_tdata[0] === 1'b1) begin
          n_hits++;
        end
        if (expected_verdicts.size() == 0) begin
          flag($sformatf("verdict beat with none expected, tdata %h", m_tdata));
        end else begin
          want = expected_verdicts.pop_front();
          if (m_tdata[0] !== want.hit) begin
            flag($sformatf("match expected %b got %b", want.hit, m_tdata[0]));
          end
          if (m_tdata[1] !== want.overflow) begin
            flag($sformatf("pattern_overflow expected %b got %b", want.overflow, m_tdata[1]));
          end
          if (m_tdata[7:2] !== 6'd0) begin
            flag($sformatf("padding expected 0 got %b", m_tdata[7:2]));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (cmd_t'(s_tuser))
          CMD_CLEAR: begin
            pattern_len = 0;
            overflowed = 1'b0;
            live = start_positions();
          end
          CMD_APPEND: begin
            if (pattern_len < DEPTH) begin
              pattern[pattern_len] = s_tdata;
              pattern_len++;
            end else begin
              overflowed = 1'b1;
            end
            live = start_positions();
          end
          CMD_SUBJECT: begin
            live = step_positions(live, s_tdata);
            if (s_tlast) begin
              want.hit = (pattern_len != 0) && live[pattern_len];
              want.overflow = overflowed;
              expected_verdicts.push_back(want);
              live = start_positions();
            end
          end
          CMD_EMPTY: begin
            want.hit = 1'b0;
            want.overflow = overflowed;
            expected_verdicts.push_back(want);
            live = start_positions();
          end
        endcase
      end
    end
    mismatches <= n_bad;
    pending <= expected_verdicts.size();
    verdicts <= n_verdicts;
    hits <= n_hits;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench: stimulus and verdict for the wildcard glob matcher

module testbench;
  import wgm_pkg::*;

  localparam int TARGET_BEATS = 1450;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] ch
  logic [1:0] s_tuser = 2'd0;    // [1:0] cmd
  logic       s_tlast = 1'b0;    // last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] match, [1] pattern_overflow, [7:2] zero

  int mismatches;
  int pending;
  int verdicts;
  int hits;
  int beats_sent = 0;
  int overflow_patterns = 0;
  int plen;
  bit calm = 1'b0;

  logic [7:0] pat_q[$];
  logic [7:0] subj_q[$];
  logic [7:0] letters [10] = '{"a", "A", "b", "B", "z", "Z", "@", "[", 8'h60, "{"};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wildcard_glob_match u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  glob_verdict_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .verdicts   (verdicts),
    .hits       (hits)
  );

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CHAR_STAR;
    if (r < 22) return CHAR_ONE;
    if (r < 85) return letters[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic send_beat(input cmd_t cmd, input logic [7:0] ch, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= ch;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic load_pattern(input int len);
    logic [7:0] c;
    send_beat(CMD_CLEAR, 8'($urandom), 1'($urandom));
    pat_q.delete();
    repeat (len) begin
      c = pattern_char();
      pat_q.push_back(c);
      send_beat(CMD_APPEND, c, 1'($urandom));
    end
    if (len > MAX_PATTERN_DEF) begin
      overflow_patterns++;
    end
  endtask

  task automatic make_subject();
    int k;
    subj_q.delete();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        subj_q.push_back($urandom_range(0, 1) ? letters[$urandom_range(0, 9)]
                                              : 8'($urandom_range(0, 255)));
      end
    end else begin
      foreach (pat_q[i]) begin
        if (pat_q[i] == CHAR_STAR) begin
          repeat ($urandom_range(0, 3)) subj_q.push_back(letters[$urandom_range(0, 9)]);
        end else if (pat_q[i] == CHAR_ONE) begin
          subj_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          subj_q.push_back(any_case(pat_q[i]));
        end
      end
      // near misses
      if ($urandom_range(0, 2) == 0 && subj_q.size() > 0) begin
        k = $urandom_range(0, subj_q.size() - 1);
        case ($urandom_range(0, 2))
          0: subj_q[k] = letters[$urandom_range(0, 9)];
          1: subj_q.delete(k);
          default: subj_q.insert(k, letters[$urandom_range(0, 9)]);
        endcase
      end
    end
  endtask

  task automatic send_subject();
    bit cut;
    cut = ($urandom_range(0, 9) == 0);
    if (subj_q.size() == 0) begin
      send_beat(CMD_EMPTY, 8'($urandom), 1'($urandom));
    end else begin
      foreach (subj_q[i]) begin
        send_beat(CMD_SUBJECT, subj_q[i], !cut && i == subj_q.size() - 1);
      end
    end
  endtask

  initial begin
    int stall;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!m_tvalid);
        end
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty pattern and empty subject
    send_beat(CMD_SUBJECT, "a", 1'b1);
    send_beat(CMD_EMPTY, 8'hFF, 1'b1);
    // case folding, star over nothing, single wildcard
    send_beat(CMD_CLEAR, 8'hFF, 1'b1);
    send_beat(CMD_APPEND, "A", 1'b0);
    send_beat(CMD_APPEND, CHAR_STAR, 1'b0);
    send_beat(CMD_APPEND, CHAR_ONE, 1'b1);
    send_beat(CMD_SUBJECT, "a", 1'b0);
    send_beat(CMD_SUBJECT, "B", 1'b1);
    send_beat(CMD_SUBJECT, "a", 1'b1);
    // zero byte as a literal
    send_beat(CMD_CLEAR, 8'h00, 1'b0);
    send_beat(CMD_APPEND, 8'h00, 1'b0);
    send_beat(CMD_SUBJECT, 8'h00, 1'b1);
    send_beat(CMD_SUBJECT, 8'hFF, 1'b1);
    // pattern change with a subject half streamed
    send_beat(CMD_CLEAR, 8'h00, 1'b0);
    send_beat(CMD_APPEND, CHAR_STAR, 1'b0);
    send_beat(CMD_SUBJECT, "x", 1'b0);
    send_beat(CMD_APPEND, "b", 1'b0);
    send_beat(CMD_SUBJECT, "B", 1'b1);
    // lone star, then empty subject cutting a subject short
    send_beat(CMD_CLEAR, 8'hFF, 1'b1);
    send_beat(CMD_APPEND, CHAR_STAR, 1'b1);
    send_beat(CMD_SUBJECT, "Z", 1'b1);
    send_beat(CMD_SUBJECT, "q", 1'b0);
    send_beat(CMD_EMPTY, 8'h00, 1'b0);
    send_beat(CMD_SUBJECT, "@", 1'b1);

    while (beats_sent < TARGET_BEATS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        load_pattern(plen);
        repeat ($urandom_range(1, 5)) begin
          make_subject();
          send_subject();
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
      end
    end
    s_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("drove %0d input beats, including %0d patterns longer than the store",
             beats_sent, overflow_patterns);
    $display("checked %0d verdict beats, %0d of them matches", verdicts, hits);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wgm_pkg.sv
rtl/core/wgm_cell.sv
rtl/core/wildcard_glob_match.sv
rtl/core/wgm_checker.sv
test/glob_verdict_checker.sv
test/testbench.sv
